>>> rtl/mice_pkg.sv
// ---------------------------------------------------------------------------
// mice_pkg
// Shared types, constants and helpers of the Mic-E position frame encoder.
// ---------------------------------------------------------------------------
package mice_pkg;

  localparam int unsigned FrameLen  = 30;
  localparam int unsigned CntW      = 5;
  localparam logic [CntW-1:0] LastIdx = CntW'(FrameLen - 1);

  localparam logic [47:0] CallsignReset = 48'h2020_2020_2020;

  // coordinate limits, hundredths of an arc minute
  localparam logic [19:0] LatMaxHmin = 20'd540000;
  localparam logic [20:0] LonMaxHmin = 21'd1080000;

  // altitude clamp and offset, metres
  localparam logic signed [20:0] AltMin    = -21'sd10000;
  localparam logic signed [20:0] AltMax    = 21'sd743570;
  localparam logic [21:0]        AltOffset = 22'd10000;
  localparam logic [19:0]        AltTop    = 20'd753570;

  // reciprocal constants: q = (x * M) >> S, exact over the value range
  localparam logic [19:0] Recip6000 = 20'd715828;   // shift 32
  localparam logic [20:0] Recip8281 = 21'd2074613;  // shift 34
  localparam logic [12:0] Recip100  = 13'd5243;     // shift 19
  localparam logic [13:0] Recip91   = 14'd11523;    // shift 20
  localparam logic [7:0]  Recip10   = 8'd205;       // shift 11

  localparam logic [19:0] HminPerDeg = 20'd6000;
  localparam logic [20:0] B91Sq      = 21'd8281;
  localparam logic [12:0] HminPerMin = 13'd100;
  localparam logic [13:0] B91        = 14'd91;

  // fixed frame bytes and character biases
  localparam logic [7:0] DigHi      = 8'h50;
  localparam logic [7:0] DigLo      = 8'h30;
  localparam logic [7:0] DestSsid   = 8'h02;
  localparam logic [7:0] SrcSsid    = 8'h01;
  localparam logic [7:0] UiControl  = 8'h03;
  localparam logic [7:0] NoLayer3   = 8'hF0;
  localparam logic [7:0] MiceType   = 8'h60;
  localparam logic [7:0] CharBias   = 8'd28;
  localparam logic [7:0] B91Bias    = 8'd33;
  localparam logic [7:0] SymCode    = 8'h6D;  // 'm'
  localparam logic [7:0] SymTable   = 8'h2F;  // '/'
  localparam logic [7:0] TelemMark  = 8'h27;  // apostrophe
  localparam logic [7:0] AltEnd     = 8'h7D;  // '}'

  typedef struct packed {
    logic       south;
    logic       west;
    logic [6:0] lat_deg;
    logic [5:0] lat_min;
    logic [6:0] lat_hun;
    logic [7:0] lon_deg;
    logic [5:0] lon_min;
    logic [6:0] lon_hun;
    logic [6:0] alt_hi;
    logic [6:0] alt_mid;
    logic [6:0] alt_lo;
  } mice_pos_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } mice_digits_t;

  // decimal split of a value below 128
  function automatic mice_digits_t split10(input logic [6:0] x);
    logic [14:0]  prod;
    logic [3:0]   q;
    logic [6:0]   r;
    mice_digits_t d;
    prod   = 15'(x) * 15'(Recip10);
    q      = prod[14:11];
    r      = x - 7'(q) * 7'd10;
    d.tens = q;
    d.ones = r[3:0];
    return d;
  endfunction

endpackage

>>> rtl/mic_e_position_frame_encoder.sv
// ---------------------------------------------------------------------------
// mic_e_position_frame_encoder
// Encodes one position into the 30-byte Mic-E body of an AX.25 UI frame.
//
//   channel   direction  signals                                      unit
//   in        request    in_valid/in_ready, latitude_hmin,            position
//                        longitude_hmin, altitude_m
//   out       result     out_valid/out_ready, frame_byte, last_byte   byte
//   cfg       write      cfg_write_en, cfg_write_data                 callsign
//
// Each request yields 30 bytes, one per cycle while the output does not
// stall; the byte serializer takes the next position as the last byte of a
// frame is stepped out. A request passes the input register, five arithmetic
// stages and the frame and output registers before its first byte appears.
// Up to six further requests queue in the pipeline while a frame streams.
// Synchronous reset empties all stages and sets the callsign to six spaces.
// ---------------------------------------------------------------------------
module mic_e_position_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [47:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [20:0] latitude_hmin,
  input  logic [21:0] longitude_hmin,
  input  logic [20:0] altitude_m,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        last_byte
);

  logic [47:0]         callsign;
  logic                req_valid, split_ready;
  logic [20:0]         lat_q;
  logic [21:0]         lon_q;
  logic [20:0]         alt_q;
  logic                pos_valid, pos_ready;
  mice_pkg::mice_pos_t pos;

  assign in_ready = !req_valid || split_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      callsign  <= mice_pkg::CallsignReset;
      req_valid <= 1'b0;
    end else begin
      if (cfg_write_en) callsign <= cfg_write_data;
      if (in_ready) req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lat_q <= latitude_hmin;
      lon_q <= longitude_hmin;
      alt_q <= altitude_m;
    end
  end

  mice_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (split_ready),
    .lat_raw   (lat_q),
    .lon_raw   (lon_q),
    .alt_raw   (alt_q),
    .pos_valid (pos_valid),
    .pos_ready (pos_ready),
    .pos       (pos)
  );

  mice_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .callsign   (callsign),
    .pos_valid  (pos_valid),
    .pos_ready  (pos_ready),
    .pos        (pos),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

endmodule

>>> rtl/mice_split.sv
// ---------------------------------------------------------------------------
// mice_split
// Pipeline that turns raw coordinates and altitude into degree, minute and
// hundredth values and base-91 altitude digits, a multiply per stage after a.
// ---------------------------------------------------------------------------
module mice_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [20:0]          lat_raw,
  input  logic [21:0]          lon_raw,
  input  logic [20:0]          alt_raw,
  output logic                 pos_valid,
  input  logic                 pos_ready,
  output mice_pkg::mice_pos_t  pos
);

  // stage valids: a = magnitude, b = degrees, c = remainder, d = minutes, e = done
  logic va, vb, vc, vd, ve;
  logic ra, rb, rc, rd, re;

  logic        south_a, west_a, south_b, west_b, south_c, west_c, south_d, west_d;
  logic [19:0] lat_a, lat_b;
  logic [20:0] lon_a, lon_b;
  logic [19:0] alt_a, alt_b;
  logic [6:0]  lat_deg_b, lat_deg_c, lat_deg_d;
  logic [7:0]  lon_deg_b, lon_deg_c, lon_deg_d;
  logic [6:0]  alt_hi_b, alt_hi_c, alt_hi_d;
  logic [12:0] lat_rem_c, lat_rem_d, lon_rem_c, lon_rem_d;
  logic [13:0] alt_rem_c, alt_rem_d;
  logic [5:0]  lat_min_d, lon_min_d;
  logic [6:0]  alt_mid_d;

  // stage a inputs
  logic [21:0] lat_abs;
  logic [22:0] lon_abs;
  logic [19:0] lat_sat, alt_ofs;
  logic [20:0] lon_sat;
  logic [21:0] alt_sum;

  // stage b products
  logic [39:0] lat_prod;
  logic [40:0] lon_prod, alt_prod;

  // stage c
  logic [19:0] lat_diff, alt_diff;
  logic [20:0] lon_diff;

  // stage d products
  logic [25:0] lat_mp, lon_mp;
  logic [27:0] alt_mp;

  // stage e
  logic [12:0] lat_hd, lon_hd;
  logic [13:0] alt_ld;

  assign re = !ve || pos_ready;
  assign rd = !vd || re;
  assign rc = !vc || rd;
  assign rb = !vb || rc;
  assign ra = !va || rb;
  assign in_ready  = ra;
  assign pos_valid = ve;

  always_comb begin
    lat_abs = lat_raw[20] ? (22'd0 - {lat_raw[20], lat_raw}) : {1'b0, lat_raw};
    lon_abs = lon_raw[21] ? (23'd0 - {lon_raw[21], lon_raw}) : {1'b0, lon_raw};
    lat_sat = (lat_abs > 22'(mice_pkg::LatMaxHmin)) ? mice_pkg::LatMaxHmin : lat_abs[19:0];
    lon_sat = (lon_abs > 23'(mice_pkg::LonMaxHmin)) ? mice_pkg::LonMaxHmin : lon_abs[20:0];
    alt_sum = {alt_raw[20], alt_raw} + mice_pkg::AltOffset;
    if ($signed(alt_raw) < mice_pkg::AltMin) begin
      alt_ofs = 20'd0;
    end else if ($signed(alt_raw) > mice_pkg::AltMax) begin
      alt_ofs = mice_pkg::AltTop;
    end else begin
      alt_ofs = alt_sum[19:0];
    end
  end

  assign lat_prod = 40'(lat_a) * 40'(mice_pkg::Recip6000);
  assign lon_prod = 41'(lon_a) * 41'(mice_pkg::Recip6000);
  assign alt_prod = 41'(alt_a) * 41'(mice_pkg::Recip8281);

  assign lat_diff = lat_b - 20'(lat_deg_b) * mice_pkg::HminPerDeg;
  assign lon_diff = lon_b - 21'(lon_deg_b) * 21'(mice_pkg::HminPerDeg);
  assign alt_diff = alt_b - 20'(21'(alt_hi_b) * mice_pkg::B91Sq);

  assign lat_mp = 26'(lat_rem_c) * 26'(mice_pkg::Recip100);
  assign lon_mp = 26'(lon_rem_c) * 26'(mice_pkg::Recip100);
  assign alt_mp = 28'(alt_rem_c) * 28'(mice_pkg::Recip91);

  assign lat_hd = lat_rem_d - 13'(lat_min_d) * mice_pkg::HminPerMin;
  assign lon_hd = lon_rem_d - 13'(lon_min_d) * mice_pkg::HminPerMin;
  assign alt_ld = alt_rem_d - 14'(alt_mid_d) * mice_pkg::B91;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      if (ra) va <= in_valid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
      if (rd) vd <= vc;
      if (re) ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && in_valid) begin
      south_a <= lat_raw[20];
      west_a  <= lon_raw[21];
      lat_a   <= lat_sat;
      lon_a   <= lon_sat;
      alt_a   <= alt_ofs;
    end
    if (rb && va) begin
      south_b   <= south_a;
      west_b    <= west_a;
      lat_b     <= lat_a;
      lon_b     <= lon_a;
      alt_b     <= alt_a;
      lat_deg_b <= lat_prod[38:32];
      lon_deg_b <= lon_prod[39:32];
      alt_hi_b  <= alt_prod[40:34];
    end
    if (rc && vb) begin
      south_c   <= south_b;
      west_c    <= west_b;
      lat_deg_c <= lat_deg_b;
      lon_deg_c <= lon_deg_b;
      alt_hi_c  <= alt_hi_b;
      lat_rem_c <= lat_diff[12:0];
      lon_rem_c <= lon_diff[12:0];
      alt_rem_c <= alt_diff[13:0];
    end
    if (rd && vc) begin
      south_d   <= south_c;
      west_d    <= west_c;
      lat_deg_d <= lat_deg_c;
      lon_deg_d <= lon_deg_c;
      alt_hi_d  <= alt_hi_c;
      lat_rem_d <= lat_rem_c;
      lon_rem_d <= lon_rem_c;
      alt_rem_d <= alt_rem_c;
      lat_min_d <= lat_mp[24:19];
      lon_min_d <= lon_mp[24:19];
      alt_mid_d <= alt_mp[26:20];
    end
    if (re && vd) begin
      pos.south   <= south_d;
      pos.west    <= west_d;
      pos.lat_deg <= lat_deg_d;
      pos.lat_min <= lat_min_d;
      pos.lat_hun <= lat_hd[6:0];
      pos.lon_deg <= lon_deg_d;
      pos.lon_min <= lon_min_d;
      pos.lon_hun <= lon_hd[6:0];
      pos.alt_hi  <= alt_hi_d;
      pos.alt_mid <= alt_mid_d;
      pos.alt_lo  <= alt_ld[6:0];
    end
  end

endmodule

>>> rtl/mice_serializer.sv
// ---------------------------------------------------------------------------
// mice_serializer
// Holds one decoded position and walks the 30 frame bytes out through an
// output register, one byte per cycle while the output does not stall.
// ---------------------------------------------------------------------------
module mice_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [47:0]          callsign,
  input  logic                 pos_valid,
  output logic                 pos_ready,
  input  mice_pkg::mice_pos_t  pos,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           frame_byte,
  output logic                 last_byte
);

  logic                         busy;
  logic [mice_pkg::CntW-1:0]    cnt;
  mice_pkg::mice_pos_t          cur;
  logic                         step, done;
  logic [7:0]                   byte_next;
  mice_pkg::mice_digits_t       lat_deg_d, lat_min_d, lat_hun_d;
  logic                         lon_far;

  assign step      = busy && (!out_valid || out_ready);
  assign done      = step && (cnt == mice_pkg::LastIdx);
  assign pos_ready = !busy || done;

  assign lat_deg_d = mice_pkg::split10(cur.lat_deg);
  assign lat_min_d = mice_pkg::split10(7'(cur.lat_min));
  assign lat_hun_d = mice_pkg::split10(cur.lat_hun);
  // longitude offset flag: degrees below 10 or from 100 up
  assign lon_far   = (cur.lon_deg >= 8'd100) || (cur.lon_deg < 8'd10);

  always_comb begin
    case (cnt)
      5'd0:  byte_next = {mice_pkg::DigHi[6:0] | {3'd0, lat_deg_d.tens}, 1'b0};
      5'd1:  byte_next = {mice_pkg::DigLo[6:0] | {3'd0, lat_deg_d.ones}, 1'b0};
      5'd2:  byte_next = {mice_pkg::DigHi[6:0] | {3'd0, lat_min_d.tens}, 1'b0};
      5'd3:  byte_next = {(cur.south ? mice_pkg::DigLo[6:0] : mice_pkg::DigHi[6:0])
                          | {3'd0, lat_min_d.ones}, 1'b0};
      5'd4:  byte_next = {(lon_far ? mice_pkg::DigHi[6:0] : mice_pkg::DigLo[6:0])
                          | {3'd0, lat_hun_d.tens}, 1'b0};
      5'd5:  byte_next = {(cur.west ? mice_pkg::DigHi[6:0] : mice_pkg::DigLo[6:0])
                          | {3'd0, lat_hun_d.ones}, 1'b0};
      5'd6:  byte_next = mice_pkg::DestSsid;
      5'd7:  byte_next = {callsign[46:40], 1'b0};
      5'd8:  byte_next = {callsign[38:32], 1'b0};
      5'd9:  byte_next = {callsign[30:24], 1'b0};
      5'd10: byte_next = {callsign[22:16], 1'b0};
      5'd11: byte_next = {callsign[14:8], 1'b0};
      5'd12: byte_next = {callsign[6:0], 1'b0};
      5'd13: byte_next = mice_pkg::SrcSsid;
      5'd14: byte_next = mice_pkg::UiControl;
      5'd15: byte_next = mice_pkg::NoLayer3;
      5'd16: byte_next = mice_pkg::MiceType;
      5'd17: begin
        if (cur.lon_deg < 8'd10) begin
          byte_next = cur.lon_deg + 8'd90 + mice_pkg::CharBias;
        end else if (cur.lon_deg < 8'd100) begin
          byte_next = cur.lon_deg + mice_pkg::CharBias;
        end else if (cur.lon_deg < 8'd110) begin
          byte_next = cur.lon_deg + 8'd80 + mice_pkg::CharBias;
        end else begin
          byte_next = cur.lon_deg - 8'd100 + mice_pkg::CharBias;
        end
      end
      5'd18: byte_next = (cur.lon_min >= 6'd10) ? (8'(cur.lon_min) + mice_pkg::CharBias)
                                                : (8'(cur.lon_min) + 8'd60 + mice_pkg::CharBias);
      5'd19: byte_next = 8'(cur.lon_hun) + mice_pkg::CharBias;
      5'd20: byte_next = mice_pkg::CharBias;
      5'd21: byte_next = mice_pkg::CharBias;
      5'd22: byte_next = mice_pkg::CharBias;
      5'd23: byte_next = mice_pkg::SymCode;
      5'd24: byte_next = mice_pkg::SymTable;
      5'd25: byte_next = mice_pkg::TelemMark;
      5'd26: byte_next = 8'(cur.alt_hi) + mice_pkg::B91Bias;
      5'd27: byte_next = 8'(cur.alt_mid) + mice_pkg::B91Bias;
      5'd28: byte_next = 8'(cur.alt_lo) + mice_pkg::B91Bias;
      5'd29: byte_next = mice_pkg::AltEnd;
      default: byte_next = mice_pkg::AltEnd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pos_valid && pos_ready) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (step) begin
        cnt <= cnt + 1'b1;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pos_valid && pos_ready) begin
      cur <= pos;
    end
    if (step) begin
      frame_byte <= byte_next;
      last_byte  <= (cnt == mice_pkg::LastIdx);
    end
  end

endmodule
